[hw/rtl/lkvc_pkg.sv]
// lkvc_pkg: shared types and constants of the lru key-value cache unit
// used by lru_key_value_cache_unit, lkvc_checker and the testbench
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES_DEFAULT = 16;
    localparam int KEY_W           = 32;
    localparam int DATA_W          = 32;
    localparam int CAP_W           = 5;

    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_PUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_AGE
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/lkvc_ram.sv]
// lkvc_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module lkvc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/lru_key_value_cache_unit.sv]
// lru_key_value_cache_unit: fully associative key-value cache with lru replacement
// depends on lkvc_pkg and lkvc_ram
`default_nettype none

// Usage
//   Request channel: raise start with i_action (0 get, 1 put), i_key and i_value;
//   the transfer happens at a clock edge where start is high and busy is low.
//   Busy stays high while the request is worked on.
//   Result channel: o_strobe is high for one cycle with o_hit, o_read_value and
//   o_evicted; the receiver must take it in that cycle, there is no stall.
//   Config channel: i_cfg_valid / o_cfg_ready carry capacity_in_use on i_cfg_data;
//   write it only while the block is idle.
// Timing
//   One pass walks all ENTRIES slots through the key and age rams, one slot per
//   cycle, comparing keys and tracking the oldest and the first free slot. A
//   second pass walks the age ram again with a read-modify-write per slot.
//   A get that misses ends after the scan pass and the decide state; every other
//   request also runs the age pass. One request at a time; the next one can
//   transfer in the result cycle.
// Reset
//   Synchronous, active low: clears all valid marks and the occupancy and sets
//   the capacity to 16. The key, data and age rams are not cleared.

module lru_key_value_cache_unit
    import lkvc_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_action,
    input  wire logic signed [31:0]  i_key,
    input  wire logic signed [31:0]  i_value,
    output logic                     o_strobe,
    output logic                     o_hit,
    output logic signed [31:0]       o_read_value,
    output logic                     o_evicted,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [CAP_W-1:0]    i_cfg_data
);

    localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int AGEW  = AW;
    localparam int CMP_W = (CW > CAP_W) ? CW : CAP_W;

    t_state r_state, n_state;

    logic [CW-1:0]     r_cnt;
    logic              r_pv;
    logic [AW-1:0]     r_pidx;
    logic              r_act;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_val;
    logic              r_hit_found;
    logic [AW-1:0]     r_slot;
    logic [AGEW-1:0]   r_hit_age;
    logic              r_old_found;
    logic [AW-1:0]     r_old_idx;
    logic [AGEW-1:0]   r_old_age;
    logic              r_free_found;
    logic [AW-1:0]     r_free_idx;
    logic              r_insert;
    logic [ENTRIES-1:0] r_valid;
    logic [CW-1:0]     r_occ;
    logic [CAP_W-1:0]  r_cap;
    logic              r_strobe;
    logic              r_hit;
    logic [DATA_W-1:0] r_rd_val;
    logic              r_ev;

    // ram ports
    logic [AW-1:0]     rd_addr;
    logic [KEY_W-1:0]  key_dout;
    logic [DATA_W-1:0] data_dout;
    logic [AGEW-1:0]   age_dout;
    logic              key_we, data_we, age_we;
    logic [AW-1:0]     age_waddr;
    logic [AGEW-1:0]   age_wdata;

    // control decoded from state
    logic accept, pass_end, issue, scan_proc, decide, n_strobe;

    // datapath helpers
    logic              proc_valid, key_match, age_bump;
    logic [CMP_W-1:0]  cap_ext, cap_eff, occ_ext;
    logic              evict_now, put_miss, get_miss;
    logic [AW-1:0]     target;

    assign accept   = start && !busy;
    assign rd_addr  = r_cnt[AW-1:0];
    assign pass_end = (r_cnt == CW'(ENTRIES));

    // effective capacity clamped to 1 .. ENTRIES
    always_comb begin
        cap_ext = CMP_W'(r_cap);
        occ_ext = CMP_W'(r_occ);
        if (cap_ext == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_ext > CMP_W'(ENTRIES)) begin
            cap_eff = CMP_W'(ENTRIES);
        end else begin
            cap_eff = cap_ext;
        end
    end

    assign proc_valid = r_valid[r_pidx];
    assign key_match  = proc_valid && (key_dout == r_key);
    assign put_miss   = (r_act == ACT_PUT) && !r_hit_found;
    assign get_miss   = (r_act == ACT_GET) && !r_hit_found;
    assign evict_now  = put_miss && (occ_ext >= cap_eff);
    assign target     = (evict_now && (!r_free_found || (r_old_idx < r_free_idx)))
                        ? r_old_idx : r_free_idx;

    // younger entries age on a touch, every other valid entry ages on an insert
    assign age_bump  = proc_valid && (r_insert || (age_dout < r_hit_age));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (pass_end) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                n_state = get_miss ? ST_IDLE : ST_AGE;
            end
            ST_AGE: begin
                if (pass_end) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        busy      = 1'b1;
        issue     = 1'b0;
        scan_proc = 1'b0;
        decide    = 1'b0;
        n_strobe  = 1'b0;
        key_we    = 1'b0;
        data_we   = 1'b0;
        age_we    = 1'b0;
        age_waddr = r_pidx;
        age_wdata = age_dout + AGEW'(1);
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
            end
            ST_SCAN: begin
                issue     = !pass_end;
                scan_proc = r_pv;
            end
            ST_DECIDE: begin
                decide   = 1'b1;
                n_strobe = get_miss;
                key_we   = put_miss;
                data_we  = (r_act == ACT_PUT);
            end
            ST_AGE: begin
                issue    = !pass_end;
                n_strobe = pass_end;
                if (r_pv) begin
                    if (r_pidx == r_slot) begin
                        age_we    = 1'b1;
                        age_wdata = '0;
                    end else begin
                        age_we = age_bump;
                    end
                end
            end
            default: busy = 1'b1;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_pv     <= 1'b0;
            r_valid  <= '0;
            r_occ    <= '0;
            r_cap    <= CAP_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_pv     <= issue;
            if (accept || decide) begin
                r_cnt <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (decide && put_miss) begin
                if (!evict_now) begin
                    r_occ <= r_occ + CW'(1);
                end
                // the evicted slot drops out unless it is the one refilled
                r_valid <= (r_valid & ~(evict_now ? (ENTRIES'(1) << r_old_idx) : '0))
                           | (ENTRIES'(1) << target);
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_pidx <= rd_addr;
        if (accept) begin
            r_act        <= i_action;
            r_key        <= i_key;
            r_val        <= i_value;
            r_hit_found  <= 1'b0;
            r_old_found  <= 1'b0;
            r_free_found <= 1'b0;
        end
        if (scan_proc) begin
            if (key_match && !r_hit_found) begin
                r_hit_found <= 1'b1;
                r_slot      <= r_pidx;
                r_hit_age   <= age_dout;
            end
            if (proc_valid && (!r_old_found || (age_dout > r_old_age))) begin
                r_old_found <= 1'b1;
                r_old_idx   <= r_pidx;
                r_old_age   <= age_dout;
            end
            if (!proc_valid && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_pidx;
            end
        end
        if (decide) begin
            r_insert <= put_miss;
            r_hit    <= r_hit_found;
            r_ev     <= evict_now;
            r_rd_val <= MISS_VALUE;
            if (put_miss) begin
                r_slot <= target;
            end
        end
        // data of a get hit was read during the decide cycle
        if ((r_state == ST_AGE) && (r_cnt == '0) && !r_pv && (r_act == ACT_GET)) begin
            r_rd_val <= data_dout;
        end
    end

    lkvc_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (target),
        .i_wdata (r_key),
        .i_raddr (rd_addr),
        .o_rdata (key_dout)
    );

    lkvc_ram #(.WIDTH(DATA_W), .DEPTH(ENTRIES)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (r_hit_found ? r_slot : target),
        .i_wdata (r_val),
        .i_raddr (r_slot),
        .o_rdata (data_dout)
    );

    lkvc_ram #(.WIDTH(AGEW), .DEPTH(ENTRIES)) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (age_we),
        .i_waddr (age_waddr),
        .i_wdata (age_wdata),
        .i_raddr (rd_addr),
        .o_rdata (age_dout)
    );

    assign o_cfg_ready  = 1'b1;
    assign o_strobe     = r_strobe;
    assign o_hit        = r_hit;
    assign o_read_value = r_rd_val;
    assign o_evicted    = r_ev;

endmodule

`default_nettype wire

[hw/rtl/lkvc_checker.sv]
// lkvc_checker: port-level assertions for lru_key_value_cache_unit, bound to the top
// depends on lkvc_pkg
`default_nettype none

module lkvc_checker
    import lkvc_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               o_strobe,
    input wire logic               o_hit,
    input wire logic               o_evicted
);

    // a result is delivered as the block goes idle
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // an accepted request occupies the block
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request transfer did not raise busy");

    // only a put of a new key can evict
    a_evict_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_evicted) |-> !o_hit)
        else $error("eviction flagged on a hit");

    // one result per request, never back to back
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two results in consecutive cycles");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_strobe  (o_strobe),
    .o_hit     (o_hit),
    .o_evicted (o_evicted)
);

`default_nettype wire

[dv/lru_key_value_cache_unit_test.sv]
// lru_key_value_cache_unit_test: self-checking testbench of the lru key-value cache unit
// drives get/put requests and capacity writes, predicts every response and compares
// depends on lkvc_pkg and the lru_key_value_cache_unit rtl
`default_nettype none

module lru_key_value_cache_unit_test;
    import lkvc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS           = ENTRIES_DEFAULT;
    localparam int NUM_PHASES      = 10;
    localparam int ITEMS_PER_PHASE = 195;
    localparam int POOL_MAX        = 24;
    localparam int MAX_REPORTS     = 10;
    localparam int TIMEOUT_NS      = 2_500_000;

    typedef struct packed {
        logic        action;
        logic [31:0] key;
        logic [31:0] value;
    } cache_req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_value;
        logic        evicted;
    } cache_resp_t;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    logic                 i_action    = ACT_GET;
    logic signed [31:0]   i_key       = '0;
    logic signed [31:0]   i_value     = '0;
    logic                 o_strobe;
    logic                 o_hit;
    logic signed [31:0]   o_read_value;
    logic                 o_evicted;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CAP_W-1:0]     i_cfg_data  = '0;

    // cache contents as the predictor sees them
    logic [31:0]          tag_mem  [SLOTS];
    logic [31:0]          data_mem [SLOTS];
    logic                 live     [SLOTS];
    logic [4:0]           rank     [SLOTS];
    logic [4:0]           fill_count;
    logic [CAP_W-1:0]     cap_reg;

    cache_req_t           pending_req[$];
    cache_resp_t          expected_resp[$];
    logic                 req_taken = 1'b0;
    int                   gap_left  = 0;
    logic                 idle_on   = 1'b1;
    int                   n_errors  = 0;

    lru_key_value_cache_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_strobe     (o_strobe),
        .o_hit        (o_hit),
        .o_read_value (o_read_value),
        .o_evicted    (o_evicted),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    // applies one request to the predicted cache and returns its response
    function automatic cache_resp_t predict_access(input cache_req_t rq);
        cache_resp_t rs;
        int          slot;
        int          oldest;
        int          i;
        logic [4:0]  a;
        logic [4:0]  eff_cap;
        rs.hit        = 1'b0;
        rs.read_value = MISS_VALUE;
        rs.evicted    = 1'b0;
        slot          = -1;
        oldest        = -1;
        eff_cap       = (cap_reg == 0) ? 5'd1 : (cap_reg > SLOTS) ? 5'(SLOTS) : cap_reg;
        for (i = 0; i < SLOTS; i++) begin
            if (slot < 0 && live[i] && tag_mem[i] == rq.key) slot = i;
        end
        if (slot >= 0) begin
            rs.hit = 1'b1;
            if (rq.action == ACT_GET) rs.read_value = data_mem[slot];
            else data_mem[slot] = rq.value;
            // entries younger than the touched one age by one
            a = rank[slot];
            for (i = 0; i < SLOTS; i++) begin
                if (live[i] && i != slot && rank[i] < a) rank[i] = rank[i] + 1;
            end
            rank[slot] = '0;
        end else if (rq.action == ACT_PUT) begin
            if (fill_count >= eff_cap) begin
                for (i = 0; i < SLOTS; i++) begin
                    if (live[i] && (oldest < 0 || rank[i] > rank[oldest])) oldest = i;
                end
                if (oldest >= 0) begin
                    live[oldest] = 1'b0;
                    rank[oldest] = '0;
                    if (fill_count > 0) fill_count = fill_count - 1;
                    rs.evicted = 1'b1;
                end
            end
            // lowest free slot takes the new key
            for (i = 0; i < SLOTS; i++) begin
                if (slot < 0 && !live[i]) slot = i;
            end
            if (slot >= 0) begin
                for (i = 0; i < SLOTS; i++) begin
                    if (live[i]) rank[i] = rank[i] + 1;
                end
                tag_mem[slot]  = rq.key;
                data_mem[slot] = rq.value;
                live[slot]     = 1'b1;
                rank[slot]     = '0;
                fill_count     = fill_count + 1;
            end
        end
        return rs;
    endfunction

    // request driver: holds each request until its transfer, with random gaps
    always @(negedge i_clk) begin : request_driver
        cache_req_t rq;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || req_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (pending_req.size() > 0) begin
                rq = pending_req.pop_front();
                i_action <= rq.action;
                i_key    <= rq.key;
                i_value  <= rq.value;
                start    <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 17);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // response monitor and predictor update
    always @(posedge i_clk) begin : response_monitor
        cache_resp_t want;
        int          i;
        if (!i_rst_n) begin
            for (i = 0; i < SLOTS; i++) begin
                live[i] = 1'b0;
                rank[i] = '0;
            end
            fill_count = '0;
            cap_reg    = CAP_RESET;
            req_taken <= 1'b0;
        end else begin
            if (o_strobe) begin
                if (expected_resp.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display("error: response with none outstanding: hit %0b value %h evicted %0b",
                                 o_hit, o_read_value, o_evicted);
                end else begin
                    want = expected_resp.pop_front();
                    if (o_hit !== want.hit || o_read_value !== want.read_value ||
                        o_evicted !== want.evicted) begin
                        n_errors++;
                        if (n_errors <= MAX_REPORTS)
                            $display("error: hit %0b/%0b read_value %h/%h evicted %0b/%0b (exp/act)",
                                     want.hit, o_hit, want.read_value, o_read_value,
                                     want.evicted, o_evicted);
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) cap_reg = i_cfg_data;
            if (start && !busy)
                expected_resp.push_back(predict_access('{i_action, i_key, i_value}));
            req_taken <= start && !busy;
        end
    end

    task automatic queue_request(input logic act, input logic [31:0] k, input logic [31:0] v);
        pending_req.push_back('{act, k, v});
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_req.size() != 0 || start || expected_resp.size() != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        @(negedge i_clk);
        i_cfg_data  <= c;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [CAP_W-1:0] phase_cap [NUM_PHASES];
        logic [31:0]      key_pool  [POOL_MAX];
        logic [31:0]      k;
        int               p;
        int               n;
        int               i;
        int               eff;
        int               pool_n;

        phase_cap = '{5'd31, 5'd1, 5'd16, 5'd2, 5'd17, 5'd0,
                      CAP_W'($urandom_range(0, 31)), 5'd4,
                      CAP_W'($urandom_range(0, 31)), 5'd16};
        for (i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extreme keys and values at the reset capacity
        queue_request(ACT_GET, 32'h0000_0000, 32'h1234_5678);
        queue_request(ACT_PUT, 32'h0000_0000, 32'h7fff_ffff);
        queue_request(ACT_PUT, 32'hffff_ffff, 32'h8000_0000);
        queue_request(ACT_PUT, 32'h8000_0000, 32'h0000_0000);
        queue_request(ACT_PUT, 32'h7fff_ffff, 32'hffff_ffff);
        queue_request(ACT_GET, 32'h0000_0000, 32'h0000_0000);
        queue_request(ACT_GET, 32'hffff_ffff, 32'hffff_ffff);
        queue_request(ACT_GET, 32'h8000_0000, 32'h0000_0000);
        queue_request(ACT_GET, 32'h7fff_ffff, 32'h0000_0000);
        queue_request(ACT_PUT, 32'h8000_0000, 32'h5a5a_5a5a);
        queue_request(ACT_GET, 32'h8000_0000, 32'h0000_0000);
        queue_request(ACT_GET, 32'h0000_0001, 32'hdead_beef);
        wait_idle();

        // capacity dropped below the fill level: each new key evicts one entry
        write_capacity(5'd3);
        queue_request(ACT_PUT, 32'h0000_0001, 32'h0000_0011);
        queue_request(ACT_PUT, 32'h0000_0002, 32'h0000_0022);
        queue_request(ACT_GET, 32'h0000_0000, 32'h0000_0000);
        queue_request(ACT_GET, 32'h0000_0001, 32'h0000_0000);
        wait_idle();

        // zero capacity behaves as one entry
        write_capacity(5'd0);
        queue_request(ACT_PUT, 32'h0000_0005, 32'h0000_0055);
        queue_request(ACT_PUT, 32'h0000_0006, 32'h0000_0066);
        queue_request(ACT_GET, 32'h0000_0005, 32'h0000_0000);
        queue_request(ACT_GET, 32'h0000_0006, 32'h0000_0000);
        queue_request(ACT_PUT, 32'h0000_0006, 32'h0000_0077);
        queue_request(ACT_GET, 32'h0000_0006, 32'h0000_0000);

        for (p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            write_capacity(phase_cap[p]);
            idle_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            eff = (phase_cap[p] == 0) ? 1 : (phase_cap[p] > SLOTS) ? SLOTS : phase_cap[p];
            pool_n = eff + $urandom_range(1, 6);
            if (pool_n > POOL_MAX) pool_n = POOL_MAX;
            // keep part of the old keys so entries from earlier phases still hit
            for (i = 0; i < POOL_MAX; i++) begin
                if ($urandom_range(0, 2) == 0) begin
                    case ($urandom_range(0, 7))
                        0:       key_pool[i] = 32'h0000_0000;
                        1:       key_pool[i] = 32'hffff_ffff;
                        2:       key_pool[i] = 32'h8000_0000;
                        3:       key_pool[i] = 32'h7fff_ffff;
                        default: key_pool[i] = $urandom;
                    endcase
                end
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 9) == 0) k = $urandom;
                else k = key_pool[$urandom_range(0, pool_n - 1)];
                queue_request(($urandom_range(0, 99) < 45) ? ACT_PUT : ACT_GET, k, $urandom);
            end
        end

        wait_idle();
        repeat (2 * SLOTS + 8) @(posedge i_clk);
        if (n_errors == 0 && expected_resp.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/lkvc_pkg.sv
hw/rtl/lkvc_ram.sv
hw/rtl/lru_key_value_cache_unit.sv
hw/rtl/lkvc_checker.sv
dv/lru_key_value_cache_unit_test.sv
